FILE: src/bdq_pkg.sv
// Shared types and constants for the bounded deque with delete by value.
package bdq_pkg;

  localparam int CAPACITY_DEFAULT = 16;
  localparam int VALUE_W          = 32;
  localparam int REQ_W            = 3;
  localparam int STATUS_W         = 2;
  localparam int COUNT_W          = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_DELETE     = 3'd4
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    RD_FRONT     = 2'd0,
    RD_TAIL_M1   = 2'd1,
    RD_SLOT_NEXT = 2'd2
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_FRONT_M1 = 2'd0,
    WR_TAIL     = 2'd1,
    WR_SLOT     = 2'd2
  } wr_sel_t;

  typedef struct packed {
    logic    load;
    logic    finish;
    status_t res_status;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    front_inc;
    logic    front_dec;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    scan_init;
    logic    advance;
    logic    cap_removed;
  } cmd_t;

  typedef struct packed {
    req_t req;
    logic full;
    logic empty;
    logic match;
    logic pos_zero;
    logic pos_last;
  } stat_t;

endpackage

FILE: src/bounded_deque_with_value_delete_unit.sv
// Top level of the bounded deque with delete by value.
// Each transaction takes one request while busy is low and answers with one
// result, shown for a single cycle under done; the receiver cannot stall.
// The entry store is a single-port-read RAM, and it sets the time: a push
// finishes from the decode state, a pop waits for the RAM read, and a delete
// scans from the front until it matches; when the match is not at the front,
// each value behind the match is then read and written one slot forward. A
// miss scans every entry, and a request on an empty store, a push into a full
// store or an unused code finishes from the decode state. busy drops in the
// cycle that done is high.
module bounded_deque_with_value_delete_unit #(
  parameter int CAPACITY = bdq_pkg::CAPACITY_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [bdq_pkg::REQ_W-1:0]          req_type,
  input  logic signed [bdq_pkg::VALUE_W-1:0] value,
  output logic                               done,
  output logic [bdq_pkg::STATUS_W-1:0]       status,
  output logic signed [bdq_pkg::VALUE_W-1:0] removed_value,
  output logic [bdq_pkg::COUNT_W-1:0]        count
);

  bdq_pkg::cmd_t  cmd;
  bdq_pkg::stat_t stat;

  bdq_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy)
  );

  bdq_dpath #(
    .CAPACITY(CAPACITY)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .req_type     (req_type),
    .value        (value),
    .done         (done),
    .status       (status),
    .removed_value(removed_value),
    .count        (count)
  );

endmodule

FILE: src/bdq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/bdq_ctrl.sv
// Request sequencer: decode, pop, scan and compaction control.
module bdq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  bdq_pkg::stat_t stat,
  output bdq_pkg::cmd_t  cmd,
  output logic           busy
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_DECODE   = 6'b000010,
    S_POP_WAIT = 6'b000100,
    S_SCAN     = 6'b001000,
    S_SHIFT    = 6'b010000,
    S_SHIFT_WR = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.res_status = bdq_pkg::ST_OK;
    state_next     = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_IDLE;
        unique case (stat.req) inside
          bdq_pkg::REQ_PUSH_FRONT, bdq_pkg::REQ_PUSH_BACK: begin
            cmd.finish = 1'b1;
            if (stat.full) begin
              cmd.res_status = bdq_pkg::ST_FULL;
            end else begin
              cmd.wr_en   = 1'b1;
              cmd.cnt_inc = 1'b1;
              if (stat.req == bdq_pkg::REQ_PUSH_FRONT) begin
                cmd.wr_sel    = bdq_pkg::WR_FRONT_M1;
                cmd.front_dec = 1'b1;
              end else begin
                cmd.wr_sel = bdq_pkg::WR_TAIL;
              end
            end
          end
          bdq_pkg::REQ_POP_FRONT, bdq_pkg::REQ_POP_BACK: begin
            if (stat.empty) begin
              cmd.finish     = 1'b1;
              cmd.res_status = bdq_pkg::ST_EMPTY;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = (stat.req == bdq_pkg::REQ_POP_FRONT) ?
                           bdq_pkg::RD_FRONT : bdq_pkg::RD_TAIL_M1;
              state_next = S_POP_WAIT;
            end
          end
          bdq_pkg::REQ_DELETE: begin
            if (stat.empty) begin
              cmd.finish     = 1'b1;
              cmd.res_status = bdq_pkg::ST_EMPTY;
            end else begin
              cmd.rd_en     = 1'b1;
              cmd.rd_sel    = bdq_pkg::RD_FRONT;
              cmd.scan_init = 1'b1;
              state_next    = S_SCAN;
            end
          end
          default: begin
            cmd.finish = 1'b1;
          end
        endcase
      end
      S_POP_WAIT: begin
        cmd.cap_removed = 1'b1;
        cmd.front_inc   = (stat.req == bdq_pkg::REQ_POP_FRONT);
        cmd.cnt_dec     = 1'b1;
        cmd.finish      = 1'b1;
        state_next      = S_IDLE;
      end
      S_SCAN: begin
        if (stat.match) begin
          cmd.cap_removed = 1'b1;
          if (stat.pos_zero) begin
            cmd.front_inc = 1'b1;
            cmd.cnt_dec   = 1'b1;
            cmd.finish    = 1'b1;
            state_next    = S_IDLE;
          end else begin
            state_next = S_SHIFT;
          end
        end else if (stat.pos_last) begin
          cmd.finish     = 1'b1;
          cmd.res_status = bdq_pkg::ST_NOT_FOUND;
          state_next     = S_IDLE;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = bdq_pkg::RD_SLOT_NEXT;
          cmd.advance = 1'b1;
        end
      end
      S_SHIFT: begin
        if (stat.pos_last) begin
          cmd.cnt_dec = 1'b1;
          cmd.finish  = 1'b1;
          state_next  = S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = bdq_pkg::RD_SLOT_NEXT;
          state_next = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = bdq_pkg::WR_SLOT;
        cmd.advance = 1'b1;
        state_next  = S_SHIFT;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: src/bdq_dpath.sv
// Datapath: ring pointers, entry store, scan position and result registers.
module bdq_dpath #(
  parameter int CAPACITY = bdq_pkg::CAPACITY_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  bdq_pkg::cmd_t                        cmd,
  output bdq_pkg::stat_t                       stat,
  input  logic [bdq_pkg::REQ_W-1:0]            req_type,
  input  logic signed [bdq_pkg::VALUE_W-1:0]   value,
  output logic                                 done,
  output logic [bdq_pkg::STATUS_W-1:0]         status,
  output logic signed [bdq_pkg::VALUE_W-1:0]   removed_value,
  output logic [bdq_pkg::COUNT_W-1:0]          count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = CW + 1;
  localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);
  localparam logic [SW-1:0] CAP_S     = SW'(CAPACITY);
  localparam logic [CW-1:0] CAP_C     = CW'(CAPACITY);

  logic [AW-1:0]                 front;
  logic [CW-1:0]                 cnt;
  logic [AW-1:0]                 pos;
  logic [AW-1:0]                 slot;
  logic [bdq_pkg::REQ_W-1:0]     req_q;
  logic [bdq_pkg::VALUE_W-1:0]   val_q;
  logic [bdq_pkg::VALUE_W-1:0]   removed_q;

  logic [CW-1:0]                 cnt_next;
  logic [bdq_pkg::VALUE_W-1:0]   removed_next;
  logic [AW-1:0]                 front_m1;
  logic [AW-1:0]                 front_p1;
  logic [AW-1:0]                 slot_p1;
  logic [SW-1:0]                 sum;
  logic [SW-1:0]                 sum_m1;
  logic [SW-1:0]                 tail_s;
  logic [SW-1:0]                 tail_m1_s;
  logic [AW-1:0]                 raddr;
  logic [AW-1:0]                 waddr;
  logic [bdq_pkg::VALUE_W-1:0]   wdata;
  logic [bdq_pkg::VALUE_W-1:0]   rdata;

  assign front_m1  = (front == '0) ? LAST_SLOT : front - 1'b1;
  assign front_p1  = (front == LAST_SLOT) ? '0 : front + 1'b1;
  assign slot_p1   = (slot == LAST_SLOT) ? '0 : slot + 1'b1;
  assign sum       = SW'(front) + SW'(cnt);
  assign sum_m1    = sum - 1'b1;
  assign tail_s    = (sum >= CAP_S) ? sum - CAP_S : sum;
  assign tail_m1_s = (sum_m1 >= CAP_S) ? sum_m1 - CAP_S : sum_m1;

  always_comb begin
    unique case (cmd.rd_sel)
      bdq_pkg::RD_FRONT:     raddr = front;
      bdq_pkg::RD_TAIL_M1:   raddr = tail_m1_s[AW-1:0];
      bdq_pkg::RD_SLOT_NEXT: raddr = slot_p1;
      default:               raddr = front;
    endcase
  end

  always_comb begin
    wdata = val_q;
    unique case (cmd.wr_sel)
      bdq_pkg::WR_FRONT_M1: waddr = front_m1;
      bdq_pkg::WR_TAIL:     waddr = tail_s[AW-1:0];
      bdq_pkg::WR_SLOT: begin
        waddr = slot;
        wdata = rdata;
      end
      default:              waddr = front_m1;
    endcase
  end

  bdq_ram #(
    .WIDTH(bdq_pkg::VALUE_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.wr_en),
    .waddr(waddr),
    .wdata(wdata),
    .re   (cmd.rd_en),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign cnt_next     = cnt + CW'(cmd.cnt_inc) - CW'(cmd.cnt_dec);
  assign removed_next = cmd.cap_removed ? rdata : removed_q;

  assign stat.req      = bdq_pkg::req_t'(req_q);
  assign stat.full     = (cnt == CAP_C);
  assign stat.empty    = (cnt == '0);
  assign stat.match    = (rdata == val_q);
  assign stat.pos_zero = (pos == '0);
  assign stat.pos_last = ((CW'(pos) + CW'(1)) == cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      cnt  <= cnt_next;
      done <= cmd.finish;
      if (cmd.front_inc) begin
        front <= front_p1;
      end else if (cmd.front_dec) begin
        front <= front_m1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q     <= req_type;
      val_q     <= value;
      removed_q <= '0;
    end else begin
      removed_q <= removed_next;
    end
    if (cmd.scan_init) begin
      pos  <= '0;
      slot <= front;
    end else if (cmd.advance) begin
      pos  <= pos + 1'b1;
      slot <= slot_p1;
    end
    if (cmd.finish) begin
      status        <= cmd.res_status;
      removed_value <= $signed(removed_next);
      count         <= bdq_pkg::COUNT_W'(cnt_next);
    end
  end

endmodule

FILE: src/bdq_checker.sv
// Port-level checks for the bounded deque, bound to the top level.
module bdq_checker #(
  parameter int CAPACITY = bdq_pkg::CAPACITY_DEFAULT
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               start,
  input logic                               busy,
  input logic                               done,
  input logic [bdq_pkg::STATUS_W-1:0]       status,
  input logic signed [bdq_pkg::VALUE_W-1:0] removed_value,
  input logic [bdq_pkg::COUNT_W-1:0]        count
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while still busy");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    done && (status == bdq_pkg::ST_EMPTY) |-> (count == '0))
    else $error("empty status with nonzero count");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    done && (status == bdq_pkg::ST_FULL) |-> (count == bdq_pkg::COUNT_W'(CAPACITY)))
    else $error("full status with count below capacity");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && (status != bdq_pkg::ST_OK) |-> (removed_value == '0))
    else $error("failed transaction returned a removed value");

endmodule

bind bounded_deque_with_value_delete_unit bdq_checker #(
  .CAPACITY(CAPACITY)
) u_bdq_checker (.*);
